// ===== rtl/mrh_pkg.sv =====
// mrh_pkg: shared types and constants of the member registry message hub
// message ids, action and status codes, command and response words between
// the hub core and its list and queue engines; no dependencies
package mrh_pkg;

	// message ids
	localparam logic [31:0] ID_REGISTER   = 32'h000F_0004;
	localparam logic [31:0] ID_IGNORE_LO  = 32'h000F_0005;
	localparam logic [31:0] ID_IGNORE_HI  = 32'h000F_0007;
	localparam logic [31:0] ID_UNREGISTER = 32'h000F_0008;

	typedef enum logic [1:0] {
		ACT_FRAME      = 2'd0,
		ACT_MESSAGE    = 2'd1,
		ACT_READ_LIST  = 2'd2,
		ACT_READ_QUEUE = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		ST_FRAME      = 4'd0,
		ST_NEW        = 4'd1,
		ST_UPDATED    = 4'd2,
		ST_MISMATCH   = 4'd3,
		ST_LIST_FULL  = 4'd4,
		ST_IGNORED    = 4'd5,
		ST_REMOVED    = 4'd6,
		ST_NOT_FOUND  = 4'd7,
		ST_DEFERRED   = 4'd8,
		ST_QUEUE_FULL = 4'd9,
		ST_READ_OK    = 4'd10,
		ST_BAD_INDEX  = 4'd11
	} status_t;

	typedef enum logic [1:0] {
		LOP_REG   = 2'd0,
		LOP_UNREG = 2'd1,
		LOP_READ  = 2'd2
	} list_op_t;

	typedef enum logic [1:0] {
		QOP_FRAME  = 2'd0,
		QOP_APPEND = 2'd1,
		QOP_READ   = 2'd2
	} queue_op_t;

	typedef struct packed {
		list_op_t    op;
		logic [31:0] handle;
		logic [15:0] value;
		logic [4:0]  index;
	} list_cmd_t;

	typedef struct packed {
		status_t     status;
		logic        ack;
		logic [31:0] ack_target;
		logic [31:0] read_handle;
		logic [15:0] read_value;
	} list_resp_t;

	typedef struct packed {
		queue_op_t          op;
		logic [31:0]        msg_id;
		logic [31:0]        sender;
		logic signed [31:0] payload;
		logic [4:0]         index;
	} queue_cmd_t;

	typedef struct packed {
		status_t            status;
		logic [31:0]        read_handle;
		logic [31:0]        read_msg_id;
		logic signed [31:0] read_value;
	} queue_resp_t;

endpackage

// ===== rtl/mrh_list.sv =====
// mrh_list: registration list engine, handle and value kept in one
// synchronous memory; scans, updates, appends and compacts one entry a cycle
// depends on mrh_pkg
module mrh_list import mrh_pkg::*; #(
	parameter int LIST_DEPTH = 32,
	localparam int LA = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
	localparam int LC = $clog2(LIST_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  list_cmd_t     cmd,
	output logic          resp_valid,
	output list_resp_t    resp,
	output logic [LC-1:0] total
);

	typedef struct packed {
		logic [31:0] handle;
		logic [15:0] value;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_READ_WAIT
	} state_t;

	state_t        state_q;
	list_op_t      op_q;
	logic [31:0]   handle_q;
	logic [15:0]   value_q;
	logic [LC-1:0] total_q;
	logic [LC-1:0] rd_ptr_q;
	logic          chk_vld_s1;
	logic [LA-1:0] chk_addr_s1;
	logic          found_q;
	logic          resp_valid_q;
	list_resp_t    resp_q;

	entry_t        mem [LIST_DEPTH];
	entry_t        rd_data_q;
	logic          rd_en;
	logic [LA-1:0] rd_addr;
	logic          we;
	logic [LA-1:0] wa;
	entry_t        wd;

	logic          idx_ok;
	logic          issue;
	logic          match;
	logic          drained;
	logic          full;

	assign idx_ok  = (LC+5)'(cmd.index) < (LC+5)'(total_q);
	assign issue   = (state_q == S_SCAN) && (rd_ptr_q < total_q);
	assign match   = chk_vld_s1 && (rd_data_q.handle == handle_q);
	assign drained = (state_q == S_SCAN) && !issue && !chk_vld_s1;
	assign full    = total_q == LC'(LIST_DEPTH);

	// memory port control; reads run ahead of writes by one entry for an
	// update and two for a compaction move, so a read never hits the entry
	// being written back
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		we      = 1'b0;
		wa      = '0;
		wd      = '{handle: handle_q, value: value_q};
		case (state_q)
			S_IDLE: begin
				if (cmd_valid && cmd.op == LOP_READ && idx_ok) begin
					rd_en   = 1'b1;
					rd_addr = LA'(cmd.index);
				end
			end
			S_SCAN: begin
				if (issue) begin
					rd_en   = 1'b1;
					rd_addr = rd_ptr_q[LA-1:0];
				end
				if (op_q == LOP_REG && match) begin
					we = 1'b1;
					wa = chk_addr_s1;
				end
				if (op_q == LOP_UNREG && chk_vld_s1 && found_q) begin
					// compaction: move this entry down by one
					we = 1'b1;
					wa = chk_addr_s1 - LA'(1);
					wd = rd_data_q;
				end
				if (drained && op_q == LOP_REG && !found_q && !full) begin
					we = 1'b1;
					wa = total_q[LA-1:0];
				end
			end
			default: ;
		endcase
	end

	// list memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= LOP_REG;
			handle_q     <= '0;
			value_q      <= '0;
			total_q      <= '0;
			rd_ptr_q     <= '0;
			chk_vld_s1   <= 1'b0;
			chk_addr_s1  <= '0;
			found_q      <= 1'b0;
			resp_valid_q <= 1'b0;
			resp_q       <= '0;
		end else begin
			resp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						op_q       <= cmd.op;
						handle_q   <= cmd.handle;
						value_q    <= cmd.value;
						rd_ptr_q   <= '0;
						chk_vld_s1 <= 1'b0;
						found_q    <= 1'b0;
						if (cmd.op == LOP_READ) begin
							if (idx_ok) begin
								state_q <= S_READ_WAIT;
							end else begin
								resp_valid_q  <= 1'b1;
								resp_q        <= '0;
								resp_q.status <= ST_BAD_INDEX;
							end
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					chk_vld_s1  <= issue;
					chk_addr_s1 <= rd_ptr_q[LA-1:0];
					if (issue) begin
						rd_ptr_q <= LC'(rd_ptr_q + 1'b1);
					end
					if (match) begin
						found_q <= 1'b1;
					end
					if (drained) begin
						state_q      <= S_IDLE;
						resp_valid_q <= 1'b1;
						resp_q       <= '0;
						if (op_q == LOP_REG) begin
							if (found_q) begin
								resp_q.status     <= ST_UPDATED;
								resp_q.ack        <= 1'b1;
								resp_q.ack_target <= handle_q;
							end else if (full) begin
								resp_q.status <= ST_LIST_FULL;
							end else begin
								total_q           <= LC'(total_q + 1'b1);
								resp_q.status     <= ST_NEW;
								resp_q.ack        <= 1'b1;
								resp_q.ack_target <= handle_q;
							end
						end else if (found_q) begin
							total_q       <= LC'(total_q - 1'b1);
							resp_q.status <= ST_REMOVED;
						end else begin
							resp_q.status <= ST_NOT_FOUND;
						end
					end
				end
				S_READ_WAIT: begin
					state_q            <= S_IDLE;
					resp_valid_q       <= 1'b1;
					resp_q             <= '0;
					resp_q.status      <= ST_READ_OK;
					resp_q.read_handle <= rd_data_q.handle;
					resp_q.read_value  <= rd_data_q.value;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign resp_valid = resp_valid_q;
	assign resp       = resp_q;
	assign total      = total_q;

endmodule

// ===== rtl/mrh_queue.sv =====
// mrh_queue: deferred message queue in one synchronous memory;
// appends at the fill count, reads by index, frame start empties it
// depends on mrh_pkg
module mrh_queue import mrh_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
	localparam int QC = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  queue_cmd_t    cmd,
	output logic          resp_valid,
	output queue_resp_t   resp,
	output logic [QC-1:0] total
);

	typedef struct packed {
		logic [31:0]        msg_id;
		logic [31:0]        sender;
		logic signed [31:0] payload;
	} entry_t;

	entry_t        mem [QUEUE_DEPTH];
	entry_t        rd_data_q;
	logic [QC-1:0] total_q;
	logic          rd_pend_q;
	logic          resp_valid_q;
	queue_resp_t   resp_q;

	logic          idx_ok;
	logic          full;
	logic          rd_en;
	logic          we;

	assign idx_ok = (QC+5)'(cmd.index) < (QC+5)'(total_q);
	assign full   = total_q == QC'(QUEUE_DEPTH);
	assign rd_en  = cmd_valid && cmd.op == QOP_READ && idx_ok;
	assign we     = cmd_valid && cmd.op == QOP_APPEND && !full;

	// queue memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[total_q[QA-1:0]] <= '{msg_id: cmd.msg_id, sender: cmd.sender,
				payload: cmd.payload};
		end
		if (rd_en) begin
			rd_data_q <= mem[QA'(cmd.index)];
		end
	end

	// count and response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q      <= '0;
			rd_pend_q    <= 1'b0;
			resp_valid_q <= 1'b0;
			resp_q       <= '0;
		end else begin
			resp_valid_q <= 1'b0;
			rd_pend_q    <= rd_en;
			if (rd_pend_q) begin
				resp_valid_q       <= 1'b1;
				resp_q.status      <= ST_READ_OK;
				resp_q.read_handle <= rd_data_q.sender;
				resp_q.read_msg_id <= rd_data_q.msg_id;
				resp_q.read_value  <= rd_data_q.payload;
			end
			if (cmd_valid && !rd_en) begin
				resp_valid_q <= 1'b1;
				resp_q       <= '0;
				case (cmd.op)
					QOP_FRAME: begin
						total_q       <= '0;
						resp_q.status <= ST_FRAME;
					end
					QOP_APPEND: begin
						if (full) begin
							resp_q.status <= ST_QUEUE_FULL;
						end else begin
							total_q       <= QC'(total_q + 1'b1);
							resp_q.status <= ST_DEFERRED;
						end
					end
					default: begin
						resp_q.status <= ST_BAD_INDEX;
					end
				endcase
			end
		end
	end

	assign resp_valid = resp_valid_q;
	assign resp       = resp_q;
	assign total      = total_q;

endmodule

// ===== rtl/member_registry_message_hub_core.sv =====
// member_registry_message_hub_core: top level of the message hub
// decodes items, dispatches to the list and queue engines or answers locally, registers results
// depends on mrh_pkg, mrh_list, mrh_queue
//
// usage
//   an item is taken at a rising edge with start high and busy low; busy then
//   stays high until the result word goes out. each item gives one result
//   word, shown for one cycle with done high; done cannot be held off, so
//   capture the result in the cycle it is shown. a new start may be given in
//   the same cycle as done.
//   own_slot must be written with own_slot_we / own_slot_wdata only while idle; the block does not enforce it.
// item handling
//   list or queue read: one synchronous memory read, skipped when the
//   index is at or beyond the count
//   register / unregister: the list memory is scanned one entry a cycle
//   and unregister compacts in the same pass
// one item at a time: a new item is taken only once the last one's result goes out
// reset
//   member and queue counts and own_slot go to zero; memory contents are not
//   cleared, entries beyond the counts are never returned
module member_registry_message_hub_core import mrh_pkg::*; #(
	parameter int LIST_DEPTH  = 32,
	parameter int QUEUE_DEPTH = 16,
	localparam int LC = $clog2(LIST_DEPTH + 1),
	localparam int QC = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               own_slot_we,
	input  logic [7:0]         own_slot_wdata,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic [31:0]        msg_id,
	input  logic [31:0]        sender,
	input  logic [7:0]         sender_slot,
	input  logic signed [31:0] payload,
	input  logic [4:0]         entry_index,
	output logic               done,
	output logic [3:0]         status,
	output logic               send_ack,
	output logic [31:0]        ack_target,
	output logic [31:0]        read_handle,
	output logic [31:0]        read_msg_id,
	output logic signed [31:0] read_value,
	output logic [LC-1:0]      member_count,
	output logic [QC-1:0]      deferred_count
);

	logic [7:0]         own_slot_q;
	logic               busy_q;
	logic               local_vld_q;
	status_t            local_status_q;
	logic               done_q;
	status_t            status_q;
	logic               send_ack_q;
	logic [31:0]        ack_target_q;
	logic [31:0]        read_handle_q;
	logic [31:0]        read_msg_id_q;
	logic signed [31:0] read_value_q;
	logic [LC-1:0]      member_count_q;
	logic [QC-1:0]      deferred_count_q;

	logic               accept;
	logic               list_cmd_valid;
	list_cmd_t          list_cmd;
	logic               list_resp_valid;
	list_resp_t         list_resp;
	logic [LC-1:0]      list_total;
	logic               queue_cmd_valid;
	queue_cmd_t         queue_cmd;
	logic               queue_resp_valid;
	queue_resp_t        queue_resp;
	logic [QC-1:0]      queue_total;
	logic               local_hit;
	status_t            local_status;

	assign accept = start && !busy_q;

	// item decode and dispatch
	always_comb begin
		list_cmd_valid  = 1'b0;
		queue_cmd_valid = 1'b0;
		local_hit       = 1'b0;
		local_status    = ST_IGNORED;
		list_cmd        = '{op: LOP_READ, handle: sender, value: payload[15:0],
			index: entry_index};
		queue_cmd       = '{op: QOP_READ, msg_id: msg_id, sender: sender,
			payload: payload, index: entry_index};
		case (action_t'(action))
			ACT_FRAME: begin
				queue_cmd_valid = accept;
				queue_cmd.op    = QOP_FRAME;
			end
			ACT_MESSAGE: begin
				if (msg_id == ID_REGISTER) begin
					if (sender_slot != own_slot_q) begin
						local_hit    = accept;
						local_status = ST_MISMATCH;
					end else begin
						list_cmd_valid = accept;
						list_cmd.op    = LOP_REG;
					end
				end else if (msg_id >= ID_IGNORE_LO && msg_id <= ID_IGNORE_HI) begin
					local_hit    = accept;
					local_status = ST_IGNORED;
				end else if (msg_id == ID_UNREGISTER) begin
					list_cmd_valid = accept;
					list_cmd.op    = LOP_UNREG;
				end else begin
					queue_cmd_valid = accept;
					queue_cmd.op    = QOP_APPEND;
				end
			end
			ACT_READ_LIST: begin
				list_cmd_valid = accept;
			end
			ACT_READ_QUEUE: begin
				queue_cmd_valid = accept;
			end
			default: ;
		endcase
	end

	mrh_list #(
		.LIST_DEPTH(LIST_DEPTH)
	) u_list (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (list_cmd_valid),
		.cmd        (list_cmd),
		.resp_valid (list_resp_valid),
		.resp       (list_resp),
		.total      (list_total)
	);

	mrh_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (queue_cmd_valid),
		.cmd        (queue_cmd),
		.resp_valid (queue_resp_valid),
		.resp       (queue_resp),
		.total      (queue_total)
	);

	// config register, busy flag and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_slot_q       <= '0;
			busy_q           <= 1'b0;
			local_vld_q      <= 1'b0;
			local_status_q   <= ST_IGNORED;
			done_q           <= 1'b0;
			status_q         <= ST_FRAME;
			send_ack_q       <= 1'b0;
			ack_target_q     <= '0;
			read_handle_q    <= '0;
			read_msg_id_q    <= '0;
			read_value_q     <= '0;
			member_count_q   <= '0;
			deferred_count_q <= '0;
		end else begin
			if (own_slot_we) begin
				own_slot_q <= own_slot_wdata;
			end
			local_vld_q <= local_hit;
			if (local_hit) begin
				local_status_q <= local_status;
			end
			done_q <= list_resp_valid || queue_resp_valid || local_vld_q;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (list_resp_valid || queue_resp_valid || local_vld_q) begin
				busy_q <= 1'b0;
			end
			member_count_q   <= list_total;
			deferred_count_q <= queue_total;
			if (list_resp_valid) begin
				status_q      <= list_resp.status;
				send_ack_q    <= list_resp.ack;
				ack_target_q  <= list_resp.ack_target;
				read_handle_q <= list_resp.read_handle;
				read_msg_id_q <= '0;
				read_value_q  <= {{16{list_resp.read_value[15]}}, list_resp.read_value};
			end else if (queue_resp_valid) begin
				status_q      <= queue_resp.status;
				send_ack_q    <= 1'b0;
				ack_target_q  <= '0;
				read_handle_q <= queue_resp.read_handle;
				read_msg_id_q <= queue_resp.read_msg_id;
				read_value_q  <= queue_resp.read_value;
			end else if (local_vld_q) begin
				status_q      <= local_status_q;
				send_ack_q    <= 1'b0;
				ack_target_q  <= '0;
				read_handle_q <= '0;
				read_msg_id_q <= '0;
				read_value_q  <= '0;
			end
		end
	end

	assign busy           = busy_q;
	assign done           = done_q;
	assign status         = status_q;
	assign send_ack       = send_ack_q;
	assign ack_target     = ack_target_q;
	assign read_handle    = read_handle_q;
	assign read_msg_id    = read_msg_id_q;
	assign read_value     = read_value_q;
	assign member_count   = member_count_q;
	assign deferred_count = deferred_count_q;

endmodule

// ===== rtl/mrh_checker.sv =====
// mrh_checker: port-level checks of the message hub core, bound to the top
// depends on mrh_pkg and member_registry_message_hub_core
module mrh_checker import mrh_pkg::*; #(
	parameter int LIST_DEPTH = 32,
	localparam int LC = $clog2(LIST_DEPTH + 1)
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [3:0]         status,
	input logic               send_ack,
	input logic [31:0]        ack_target,
	input logic [31:0]        read_handle,
	input logic [31:0]        read_msg_id,
	input logic signed [31:0] read_value,
	input logic [LC-1:0]      member_count
);

	// an accepted word raises busy in the next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted word");

	// a result word only closes out a word in flight
	a_done_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result word with no word in flight");

	// acknowledge only on a successful registration
	a_ack_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && send_ack |-> (status == ST_NEW || status == ST_UPDATED))
		else $error("acknowledge on wrong status");

	// a rejected read shows no data
	a_bad_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_BAD_INDEX |->
			(read_handle == '0 && read_msg_id == '0 && read_value == '0 &&
			 !send_ack && ack_target == '0))
		else $error("data shown on bad index");

	// member count stays within the list
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> member_count <= LC'(LIST_DEPTH))
		else $error("member count beyond list depth");

endmodule

bind member_registry_message_hub_core mrh_checker #(
	.LIST_DEPTH(LIST_DEPTH)
) u_mrh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.send_ack     (send_ack),
	.ack_target   (ack_target),
	.read_handle  (read_handle),
	.read_msg_id  (read_msg_id),
	.read_value   (read_value),
	.member_count (member_count)
);
